### hdl/slef_pkg.sv
package slef_pkg;

  // Frame limits
  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned BYTE_W      = 8;

  // Configuration register map
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h55;

  // Output transaction packing
  localparam int unsigned OUT_DATA_W = 32;

  // Emit request from the parser to the emitter
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
  } emit_req_t;

endpackage

### hdl/slef_ram.sv
module slef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### hdl/slef_parser.sv
module slef_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [slef_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [slef_pkg::BYTE_W-1:0]         cfg_wdata,
  input  logic                                byte_accept,
  input  logic [slef_pkg::BYTE_W-1:0]         rx_byte,
  output logic                                ram_we,
  output logic [slef_pkg::ADDR_W-1:0]         ram_waddr,
  output logic [slef_pkg::BYTE_W-1:0]         ram_wdata,
  output slef_pkg::emit_req_t                 emit_req
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_END
  } phase_t;

  phase_t                          phase_r;
  logic [slef_pkg::BYTE_W-1:0]     start_byte_r;
  logic [slef_pkg::BYTE_W-1:0]     end_byte_r;
  logic [slef_pkg::BYTE_W-1:0]     held_cmd_r;
  logic [slef_pkg::LEN_W-1:0]      held_len_r;
  logic [slef_pkg::LEN_W-1:0]      byte_count_r;
  logic [slef_pkg::LEN_W-1:0]      count_inc;
  logic                            len_too_big;

  assign count_inc   = byte_count_r + slef_pkg::LEN_W'(1);
  assign len_too_big = {1'b0, rx_byte} > 9'(slef_pkg::MAX_PAYLOAD);

  // Payload bytes go straight into the store
  assign ram_we    = byte_accept && (phase_r == PH_DATA);
  assign ram_waddr = byte_count_r[slef_pkg::ADDR_W-1:0];
  assign ram_wdata = rx_byte;

  // Correct end byte hands the frame to the emitter
  assign emit_req.start = byte_accept && (phase_r == PH_END) && (rx_byte == end_byte_r);
  assign emit_req.cmd   = held_cmd_r;
  assign emit_req.len   = held_len_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= slef_pkg::START_BYTE_RST;
      end_byte_r   <= slef_pkg::END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        slef_pkg::REG_START_BYTE: start_byte_r <= cfg_wdata;
        slef_pkg::REG_END_BYTE:   end_byte_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame parse state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      held_cmd_r   <= '0;
      held_len_r   <= '0;
      byte_count_r <= '0;
    end else if (byte_accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == start_byte_r) begin
            phase_r <= PH_CMD;
          end
        end
        PH_CMD: begin
          held_cmd_r <= rx_byte;
          phase_r    <= PH_LEN;
        end
        PH_LEN: begin
          byte_count_r <= '0;
          if (len_too_big) begin
            // oversize frame: drop, byte not rescanned as start
            phase_r    <= PH_HUNT;
            held_cmd_r <= '0;
            held_len_r <= '0;
          end else begin
            held_len_r <= rx_byte[slef_pkg::LEN_W-1:0];
            phase_r    <= (rx_byte == '0) ? PH_END : PH_DATA;
          end
        end
        PH_DATA: begin
          byte_count_r <= count_inc;
          if (count_inc >= held_len_r) begin
            phase_r <= PH_END;
          end
        end
        PH_END: begin
          held_cmd_r   <= '0;
          held_len_r   <= '0;
          byte_count_r <= '0;
          // end match wins; a wrong end byte may itself open a new frame
          if (rx_byte != end_byte_r && rx_byte == start_byte_r) begin
            phase_r <= PH_CMD;
          end else begin
            phase_r <= PH_HUNT;
          end
        end
        default: begin
          phase_r      <= PH_HUNT;
          held_cmd_r   <= '0;
          held_len_r   <= '0;
          byte_count_r <= '0;
        end
      endcase
    end
  end

endmodule

### hdl/slef_emitter.sv
module slef_emitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slef_pkg::emit_req_t                 emit_req,
  output logic                                idle,
  output logic                                ram_re,
  output logic [slef_pkg::ADDR_W-1:0]         ram_raddr,
  input  logic [slef_pkg::BYTE_W-1:0]         ram_rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [slef_pkg::BYTE_W-1:0]         frame_cmd,
  output logic [slef_pkg::LEN_W-1:0]          frame_len,
  output logic [slef_pkg::BYTE_W-1:0]         payload_byte,
  output logic [slef_pkg::ADDR_W-1:0]         payload_index,
  output logic                                payload_present,
  output logic                                frame_last
);

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_LOAD,
    E_SEND
  } emit_state_t;

  emit_state_t                     state_r;
  logic [slef_pkg::BYTE_W-1:0]     cmd_r;
  logic [slef_pkg::LEN_W-1:0]      len_r;
  logic [slef_pkg::ADDR_W-1:0]     idx_r;

  assign idle      = (state_r == E_IDLE);
  assign ram_re    = (state_r == E_READ);
  assign ram_raddr = idx_r;

  // Walk the payload store, one result in the output register at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        E_IDLE: begin
          if (emit_req.start) begin
            cmd_r <= emit_req.cmd;
            len_r <= emit_req.len;
            idx_r <= '0;
            if (emit_req.len == '0) begin
              // empty frame: single result, no store access
              frame_cmd       <= emit_req.cmd;
              frame_len       <= '0;
              payload_byte    <= '0;
              payload_index   <= '0;
              payload_present <= 1'b0;
              frame_last      <= 1'b1;
              out_valid       <= 1'b1;
              state_r         <= E_SEND;
            end else begin
              state_r <= E_READ;
            end
          end
        end
        E_READ: begin
          state_r <= E_LOAD;
        end
        E_LOAD: begin
          frame_cmd       <= cmd_r;
          frame_len       <= len_r;
          payload_byte    <= ram_rdata;
          payload_index   <= idx_r;
          payload_present <= 1'b1;
          frame_last      <= (slef_pkg::LEN_W'(idx_r) + slef_pkg::LEN_W'(1)) == len_r;
          out_valid       <= 1'b1;
          state_r         <= E_SEND;
        end
        E_SEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (frame_last) begin
              state_r <= E_IDLE;
            end else begin
              idx_r   <= idx_r + slef_pkg::ADDR_W'(1);
              state_r <= E_READ;
            end
          end
        end
        default: begin
          state_r   <= E_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hdl/sof_len_eof_frame_parser_core.sv
// SOF / command / length / payload / EOF deframer. Received bytes enter on the
// in_ stream, one per transaction, and are parsed at one byte per cycle while
// in_tready is high; payload bytes are written into a 64-entry payload RAM. A
// frame with a correct end byte is then streamed out of that RAM as one result
// per payload byte (or one empty result for a zero-length frame), and in_tready
// stays low until the last result is taken. Each payload result passes through
// a RAM read, an output register load and the handoff; the empty result needs
// only the handoff. Oversize lengths and wrong end bytes drop the frame without
// any output.
module sof_len_eof_frame_parser_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [slef_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [slef_pkg::BYTE_W-1:0]           cfg_wdata,
  // received bytes
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // [7:0] rx_byte
  // frame results
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] frame_cmd, [14:8] frame_len, [22:15] payload_byte,
  // [28:23] payload_index, [31:29] zero
  output logic [slef_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tuser,  // [0] payload_present
  output logic                                  out_tlast   // frame_last
);

  slef_pkg::emit_req_t                 emit_req;
  logic                                emit_idle;
  logic                                byte_accept;
  logic                                ram_we;
  logic [slef_pkg::ADDR_W-1:0]         ram_waddr;
  logic [slef_pkg::BYTE_W-1:0]         ram_wdata;
  logic                                ram_re;
  logic [slef_pkg::ADDR_W-1:0]         ram_raddr;
  logic [slef_pkg::BYTE_W-1:0]         ram_rdata;
  logic [slef_pkg::BYTE_W-1:0]         frame_cmd;
  logic [slef_pkg::LEN_W-1:0]          frame_len;
  logic [slef_pkg::BYTE_W-1:0]         payload_byte;
  logic [slef_pkg::ADDR_W-1:0]         payload_index;

  // Input is held off while a frame is being emitted
  assign in_tready   = emit_idle;
  assign byte_accept = in_tvalid && in_tready;

  slef_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .byte_accept (byte_accept),
    .rx_byte     (in_tdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .emit_req    (emit_req)
  );

  slef_ram #(
    .WIDTH (slef_pkg::BYTE_W),
    .DEPTH (slef_pkg::MAX_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slef_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .emit_req        (emit_req),
    .idle            (emit_idle),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .frame_cmd       (frame_cmd),
    .frame_len       (frame_len),
    .payload_byte    (payload_byte),
    .payload_index   (payload_index),
    .payload_present (out_tuser),
    .frame_last      (out_tlast)
  );

  // Output transaction packing
  assign out_tdata = {3'b000, payload_index, payload_byte, frame_len, frame_cmd};

  // No byte is taken while a result is pending
  a_no_input_while_emitting: assert property (
    @(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready
  ) else $error("input accepted while a frame result is pending");

  // The empty-frame result is always the only and last one
  a_empty_is_last: assert property (
    @(posedge clk) disable iff (!rst_n) (out_tvalid && !out_tuser) |-> out_tlast
  ) else $error("empty-frame result without frame_last");

  // Payload index stays inside the frame length
  a_index_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tuser) |-> (slef_pkg::LEN_W'(payload_index) < frame_len)
  ) else $error("payload index beyond frame length");

  // After the last result is taken, the block is ready for input again
  a_ready_after_last: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tready && out_tlast) |=> in_tready
  ) else $error("input not released after final result");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int RESET_CYC    = 10;
  localparam int DRAIN_CYC    = 16;
  localparam int LIMIT_CYC    = 200000;
  localparam int RAND_PER_SET = 75;
  localparam int NUM_SETS     = 5;
  localparam int NUM_DIR      = 27;

  // Register indexes the block decodes to nothing
  localparam logic [slef_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = slef_pkg::CFG_IDX_W'(2);
  localparam logic [slef_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = slef_pkg::CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    SCAN_SOF, TAKE_CMD, TAKE_LEN, TAKE_DATA, TAKE_EOF
  } parse_phase_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS, RDY_RANDOM, RDY_STARVED
  } rdy_mode_t;

  // One frame result as it leaves the block
  typedef struct packed {
    logic [slef_pkg::BYTE_W-1:0] cmd;
    logic [slef_pkg::LEN_W-1:0]  len;
    logic [slef_pkg::BYTE_W-1:0] data;
    logic [slef_pkg::ADDR_W-1:0] idx;
    logic                        present;
    logic                        last;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    frame_rec_t res;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [slef_pkg::CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [slef_pkg::BYTE_W-1:0]     cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [slef_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;

  sof_len_eof_frame_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Deframer shadow state
  logic [slef_pkg::BYTE_W-1:0] sof_val = slef_pkg::START_BYTE_RST;
  logic [slef_pkg::BYTE_W-1:0] eof_val = slef_pkg::END_BYTE_RST;
  parse_phase_t                ph      = SCAN_SOF;
  logic [slef_pkg::BYTE_W-1:0] cmd_r   = '0;
  logic [slef_pkg::LEN_W-1:0]  len_r   = '0;
  logic [slef_pkg::LEN_W-1:0]  cnt_r   = '0;
  logic [slef_pkg::BYTE_W-1:0] pay_mem [slef_pkg::MAX_PAYLOAD];

  frame_rec_t frame_results_q [$];
  frame_rec_t got, want;

  int        errors       = 0;
  int        bytes_sent   = 0;
  int        bytes_used   = 0;
  int        results_seen = 0;
  int        burst_left   = 0;
  int        cycle_cnt    = 0;
  int        seg_left     = 0;
  rdy_mode_t seg_mode     = RDY_ALWAYS;

  // Directed bytes under reset settings (start 0xAA, end 0x55)
  dir_row_t dir_tab [NUM_DIR] = '{
    '{8'h00, 1'b0, '0},                                           // noise, hunt
    '{8'hFF, 1'b0, '0},
    '{8'hAA, 1'b0, '0},                                           // empty frame
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h55, 1'b1, '{8'h00, 7'd0, 8'h00, 6'd0, 1'b0, 1'b1}},
    '{8'hAA, 1'b0, '0},                                           // one-byte frame
    '{8'hFF, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h55, 1'b1, '{8'hFF, 7'd1, 8'hFF, 6'd0, 1'b1, 1'b1}},
    '{8'hAA, 1'b0, '0},                                           // oversize length = SOF
    '{8'h07, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h07, 1'b0, '0},                                           // must be ignored
    '{8'hAA, 1'b0, '0},                                           // bad EOF equal to SOF
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h02, 1'b0, '0},                                           // restarted frame
    '{8'h02, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'hAA, 1'b0, '0},                                           // length 65 dropped
    '{8'h03, 1'b0, '0},
    '{8'h41, 1'b0, '0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser back to hunting, store untouched
  function automatic void clear_parser();
    ph    = SCAN_SOF;
    cmd_r = '0;
    len_r = '0;
    cnt_r = '0;
  endfunction

  // Advance the shadow deframer by one byte, queue any frame results
  function automatic void deframe_byte(input logic [7:0] b, output bit ignored);
    frame_rec_t rec;
    ignored = 1'b0;
    case (ph)
      SCAN_SOF: begin
        if (b == sof_val) ph = TAKE_CMD;
        else ignored = 1'b1;
      end
      TAKE_CMD: begin
        cmd_r = b;
        ph    = TAKE_LEN;
      end
      TAKE_LEN: begin
        cnt_r = '0;
        if (b > 8'(slef_pkg::MAX_PAYLOAD)) begin
          clear_parser();
        end else begin
          len_r = slef_pkg::LEN_W'(b);
          ph    = (b == 8'd0) ? TAKE_EOF : TAKE_DATA;
        end
      end
      TAKE_DATA: begin
        pay_mem[cnt_r[slef_pkg::ADDR_W-1:0]] = b;
        cnt_r = cnt_r + 7'd1;
        if (cnt_r >= len_r) ph = TAKE_EOF;
      end
      TAKE_EOF: begin
        if (b == eof_val) begin
          if (len_r == '0) begin
            rec = '{cmd_r, 7'd0, 8'd0, 6'd0, 1'b0, 1'b1};
            frame_results_q.push_back(rec);
          end else begin
            for (int i = 0; i < int'(len_r); i++) begin
              rec = '{cmd_r, len_r, pay_mem[i], slef_pkg::ADDR_W'(i), 1'b1,
                      i == int'(len_r) - 1};
              frame_results_q.push_back(rec);
            end
          end
          clear_parser();
        end else begin
          clear_parser();
          if (b == sof_val) ph = TAKE_CMD;
        end
      end
      default: clear_parser();
    endcase
  endfunction

  // One byte transaction; bursts with random gaps in between
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input frame_rec_t res = '0);
    bit ignored;
    int n0;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    n0 = frame_results_q.size();
    deframe_byte(b, ignored);
    // hand-typed expectation replaces the predicted one
    if (typed) begin
      while (frame_results_q.size() > n0) void'(frame_results_q.pop_back());
      frame_results_q.push_back(res);
    end
    bytes_sent++;
    if (!ignored) bytes_used++;
  endtask

  // Register write once the block has gone quiet
  task automatic write_reg(input logic [slef_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    in_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      slef_pkg::REG_START_BYTE: sof_val = val;
      slef_pkg::REG_END_BYTE:   eof_val = val;
      default: ;
    endcase
  endtask

  // Feed filler bytes until the parser is back to hunting
  task automatic settle_parser();
    logic [7:0] b;
    while (ph != SCAN_SOF) begin
      case (ph)
        TAKE_LEN: b = 8'hFF;
        TAKE_EOF: begin
          b = 8'h00;
          while (b == eof_val || b == sof_val) b = b + 8'd1;
        end
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  // Mostly short payloads, a few long ones, the maximum now and then
  function automatic logic [6:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 7'd0;
    if (r < 85) return 7'($urandom_range(1, 8));
    if (r < 96) return 7'($urandom_range(9, 40));
    if (r < 98) return 7'($urandom_range(41, 63));
    return 7'(slef_pkg::MAX_PAYLOAD);
  endfunction

  // One random frame: good, bad EOF, oversize length, or line noise
  task automatic gen_frame();
    int         kind;
    logic [6:0] len;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(sof_val);
      send_byte(8'($urandom_range(0, 255)));
      if (kind < 22) begin
        send_byte(8'($urandom_range(slef_pkg::MAX_PAYLOAD + 1, 255)));
      end else begin
        len = pick_len();
        send_byte(8'(len));
        for (int i = 0; i < int'(len); i++) send_byte(8'($urandom_range(0, 255)));
        if (kind < 32) begin
          b = 8'($urandom_range(0, 255));
          if (b == eof_val) b = b + 8'd1;
          send_byte(b);
        end else begin
          send_byte(eof_val);
        end
      end
    end
  endtask

  task automatic run_random(input int target);
    int stop_at;
    stop_at = bytes_used + target;
    while (bytes_used < stop_at) gen_frame();
  endtask

  // Receiver: segments of always-ready, random, and mostly-stalled
  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_mode <= rdy_mode_t'($urandom_range(0, 2));
      seg_left <= $urandom_range(20, 150);
    end else begin
      seg_left <= seg_left - 1;
    end
    case (seg_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_RANDOM: out_tready <= ($urandom_range(0, 9) < 6);
      default:    out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.cmd     = out_tdata[7:0];
      got.len     = out_tdata[14:8];
      got.data    = out_tdata[22:15];
      got.idx     = out_tdata[28:23];
      got.present = out_tuser;
      got.last    = out_tlast;
      results_seen++;
      if (frame_results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = frame_results_q.pop_front();
        if (got.cmd !== want.cmd)
          report_field("frame_cmd", 32'(want.cmd), 32'(got.cmd));
        if (got.len !== want.len)
          report_field("frame_len", 32'(want.len), 32'(got.len));
        if (got.data !== want.data)
          report_field("payload_byte", 32'(want.data), 32'(got.data));
        if (got.idx !== want.idx)
          report_field("payload_index", 32'(want.idx), 32'(got.idx));
        if (got.present !== want.present)
          report_field("payload_present", 32'(want.present), 32'(got.present));
        if (got.last !== want.last)
          report_field("frame_last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYC) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Main sequence
  initial begin : main_seq
    int s;
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed bytes, reset register values
    for (int r = 0; r < NUM_DIR; r++)
      send_byte(dir_tab[r].rx, dir_tab[r].typed, dir_tab[r].res);
    run_random(RAND_PER_SET);

    // register settings, extremes and start == end among them
    for (s = 0; s < NUM_SETS; s++) begin
      settle_parser();
      case (s)
        0: begin
          write_reg(slef_pkg::REG_START_BYTE, 8'h00);
          write_reg(slef_pkg::REG_END_BYTE, 8'hFF);
          write_reg(REG_SPARE_2, 8'($urandom_range(0, 255)));
        end
        1: begin
          write_reg(slef_pkg::REG_START_BYTE, 8'hFF);
          write_reg(slef_pkg::REG_END_BYTE, 8'h00);
          write_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
        end
        2: begin
          write_reg(slef_pkg::REG_START_BYTE, 8'h7E);
          write_reg(slef_pkg::REG_END_BYTE, 8'h7E);
        end
        3: begin
          write_reg(slef_pkg::REG_START_BYTE, 8'($urandom_range(0, 255)));
          write_reg(slef_pkg::REG_END_BYTE, 8'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(slef_pkg::REG_START_BYTE, slef_pkg::START_BYTE_RST);
          write_reg(slef_pkg::REG_END_BYTE, slef_pkg::END_BYTE_RST);
        end
      endcase
      run_random(RAND_PER_SET);
    end

    // drain
    in_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (frame_results_q.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected 0 pending, actual %0d pending",
               $time, frame_results_q.size());
    end

    $display("Sent %0d bytes (%0d parsed) across %0d start/end settings incl. start == end",
             bytes_sent, bytes_used, NUM_SETS + 1);
    $display("Checked %0d frame results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
